### src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int TAB_WIDTH   = 4;

    localparam int COL_W    = 8;    // cursor column / cell_col
    localparam int ROW_W    = 7;    // cursor row / cell_row
    localparam int COLS_W   = 9;    // cols_in_use
    localparam int ROWS_W   = 8;    // rows_in_use
    localparam int GLYPH_W  = 7;
    localparam int CODE_W   = 8;
    localparam int TAB_BITS = $clog2(TAB_WIDTH);
    localparam int CNT_W    = $clog2(TAB_WIDTH + 1);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // request opcodes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // configuration register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    localparam logic [CODE_W-1:0]  CHAR_NL        = 8'h0A;
    localparam logic [CODE_W-1:0]  CHAR_CR        = 8'h0D;
    localparam logic [CODE_W-1:0]  CHAR_TAB       = 8'h09;
    localparam logic [CODE_W-1:0]  CHAR_SPACE     = 8'h20;
    localparam logic [CODE_W-1:0]  CHAR_PRINT_MIN = 8'd32;
    localparam logic [CODE_W-1:0]  CHAR_HIGH      = 8'd128;
    localparam logic [GLYPH_W-1:0] GLYPH_SUBST    = 7'h3F;

    typedef enum logic [1:0] {
        ACT_DRAW   = 2'd0,
        ACT_SCROLL = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        K_PRINT,
        K_TAB,
        K_NEWLINE,
        K_RETURN,
        K_CTRL,
        K_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [GLYPH_W-1:0] glyph;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CTRL,
        B_DRAW,
        B_SCROLL
    } back_state_t;

endpackage

### src/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Accepts input requests, classifies them and queues the commands.
// ----------------------------------------------------------------------------
module tcc_front
    import tcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_opcode,
    input  logic [CODE_W-1:0] in_code,
    output logic              q_valid,
    output cmd_t              q_cmd,
    input  logic              q_pop
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              push;
    cmd_t              cmd_in;

    always_comb
    begin
        cmd_in.glyph = (in_code >= CHAR_HIGH) ? GLYPH_SUBST : in_code[GLYPH_W-1:0];
        if (in_opcode == OP_CLEAR)
        begin
            cmd_in.kind = K_CLEAR;
        end
        else if (in_code == CHAR_NL)
        begin
            cmd_in.kind = K_NEWLINE;
        end
        else if (in_code == CHAR_CR)
        begin
            cmd_in.kind = K_RETURN;
        end
        else if (in_code == CHAR_TAB)
        begin
            cmd_in.kind  = K_TAB;
            cmd_in.glyph = CHAR_SPACE[GLYPH_W-1:0];
        end
        else if (in_code >= CHAR_PRINT_MIN)
        begin
            cmd_in.kind = K_PRINT;
        end
        else
        begin
            cmd_in.kind = K_CTRL;
        end
    end

    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Executes queued commands: tracks the cursor and emits draw, scroll and
// clear results through an output register.
// ----------------------------------------------------------------------------
module tcc_back
    import tcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_sel,
    input  logic [COLS_W-1:0]  cfg_wdata,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output action_t            out_action,
    output logic [GLYPH_W-1:0] out_glyph,
    output logic [COL_W-1:0]   out_col,
    output logic [ROW_W-1:0]   out_row,
    output logic               out_last
);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   line_reg, line_next;
    logic [COLS_W-1:0]  cols_reg;
    logic [ROWS_W-1:0]  rows_reg;

    logic               ov_reg;
    action_t            oact_reg;
    logic [GLYPH_W-1:0] oglyph_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [ROW_W-1:0]   orow_reg;
    logic               olast_reg;

    logic               emit;
    action_t            e_act;
    logic [GLYPH_W-1:0] e_glyph;
    logic [COL_W-1:0]   e_col;
    logic [ROW_W-1:0]   e_row;
    logic               e_last;
    logic               out_free;

    logic [COLS_W-1:0]  cols_eff;
    logic [ROWS_W-1:0]  rows_eff;
    logic [ROW_W-1:0]   rows_last;
    logic [COLS_W-1:0]  col_inc;
    logic               wrap;
    logic [ROWS_W-1:0]  draw_line;
    logic               draw_scroll;
    logic [ROWS_W-1:0]  ctrl_line;
    logic               ctrl_scroll;
    logic [CNT_W-1:0]   tab_cnt;

    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = COLS_W'(1);
        else if (cols_reg > COLS_W'(MAX_COLUMNS))
            cols_eff = COLS_W'(MAX_COLUMNS);
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = ROWS_W'(1);
        else if (rows_reg > ROWS_W'(MAX_ROWS))
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = rows_reg;
    end

    assign rows_last   = ROW_W'(rows_eff - ROWS_W'(1));
    assign col_inc     = {1'b0, col_reg} + COLS_W'(1);
    assign wrap        = (col_inc >= cols_eff);
    assign draw_line   = {1'b0, line_reg} + ROWS_W'(wrap);
    assign draw_scroll = (draw_line >= rows_eff);
    assign ctrl_line   = {1'b0, line_reg} + ROWS_W'(cmd_reg.kind == K_NEWLINE);
    assign ctrl_scroll = (ctrl_line >= rows_eff);
    // spaces up to the next tab stop
    assign tab_cnt     = CNT_W'(TAB_WIDTH) - CNT_W'(col_reg[TAB_BITS-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind inside {K_PRINT, K_TAB})
                        state_next = B_DRAW;
                    else
                        state_next = B_CTRL;
                end
            end
            B_CTRL:
            begin
                if ((cmd_reg.kind != K_CLEAR && !ctrl_scroll) || out_free)
                    state_next = B_IDLE;
            end
            B_DRAW:
            begin
                if (out_free)
                begin
                    if (draw_scroll)
                        state_next = B_SCROLL;
                    else if (cnt_reg == CNT_W'(1))
                        state_next = B_IDLE;
                end
            end
            B_SCROLL:
            begin
                if (out_free)
                    state_next = (cnt_reg == '0) ? B_IDLE : B_DRAW;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and result generation
    always_comb
    begin
        q_pop     = 1'b0;
        cmd_next  = cmd_reg;
        cnt_next  = cnt_reg;
        col_next  = col_reg;
        line_next = line_reg;
        emit      = 1'b0;
        e_act     = ACT_DRAW;
        e_glyph   = '0;
        e_col     = '0;
        e_row     = '0;
        e_last    = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    cnt_next = (q_cmd.kind == K_TAB) ? tab_cnt : CNT_W'(1);
                end
            end
            B_CTRL:
            begin
                if (cmd_reg.kind == K_CLEAR)
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        e_act     = ACT_CLEAR;
                        e_last    = 1'b1;
                        col_next  = '0;
                        line_next = '0;
                    end
                end
                else
                begin
                    if (cmd_reg.kind == K_NEWLINE || cmd_reg.kind == K_RETURN)
                        col_next = '0;
                    if (ctrl_scroll)
                    begin
                        emit   = out_free;
                        e_act  = ACT_SCROLL;
                        e_last = 1'b1;
                        if (out_free)
                            line_next = rows_last;
                        else
                            col_next = col_reg;
                    end
                    else
                    begin
                        line_next = ctrl_line[ROW_W-1:0];
                    end
                end
            end
            B_DRAW:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    e_act     = ACT_DRAW;
                    e_glyph   = cmd_reg.glyph;
                    e_col     = col_reg;
                    e_row     = line_reg;
                    e_last    = (cnt_reg == CNT_W'(1)) && !draw_scroll;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    col_next  = wrap ? '0 : col_inc[COL_W-1:0];
                    line_next = draw_scroll ? rows_last : draw_line[ROW_W-1:0];
                end
            end
            B_SCROLL:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_act  = ACT_SCROLL;
                    e_last = (cnt_reg == '0);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oact_reg   <= e_act;
            oglyph_reg <= e_glyph;
            ocol_reg   <= e_col;
            orow_reg   <= e_row;
            olast_reg  <= e_last;
        end
        cmd_reg <= cmd_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            col_reg   <= '0;
            line_reg  <= '0;
            ov_reg    <= 1'b0;
            cols_reg  <= COLS_W'(80);
            rows_reg  <= ROWS_W'(25);
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (cfg_we && cfg_sel == REG_COLS)
                cols_reg <= cfg_wdata;
            if (cfg_we && cfg_sel == REG_ROWS)
                rows_reg <= cfg_wdata[ROWS_W-1:0];
        end
    end

    assign out_valid  = ov_reg;
    assign out_action = oact_reg;
    assign out_glyph  = oglyph_reg;
    assign out_col    = ocol_reg;
    assign out_row    = orow_reg;
    assign out_last   = olast_reg;

`ifndef SYNTHESIS
    a_draw_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DRAW) |-> (cnt_reg != '0))
        else $error("draw state with no cells left");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_act == ACT_CLEAR) |=> (col_reg == '0 && line_reg == '0))
        else $error("clear did not home the cursor");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_act == ACT_SCROLL) |-> (line_next == rows_last))
        else $error("scroll left cursor off the last row");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |-> !emit)
        else $error("result register overwritten while stalled");
`endif

endmodule

### src/text_console_cursor_controller.sv
// ----------------------------------------------------------------------------
// text_console_cursor_controller
// Character stream to console draw / scroll / clear commands.
// ----------------------------------------------------------------------------
//  channel   signals                   contents
//  s_axis    tvalid tready tdata tuser  tdata[7:0] char_code, tuser[0] opcode
//  m_axis    tvalid tready tdata tuser  tdata glyph/cell_col/cell_row,
//            tlast                      tuser[1:0] action, tlast last
//  cfg       valid ready index data     index 0 cols_in_use, 1 rows_in_use
//
//  The back sequencer fetches a command from the queue while idle, then emits
//  that command's results in turn and returns to idle before the next fetch.
//  The front takes a request each cycle while its two-entry queue has room.
//  Output stalls hold the sequencer only.
//  rst_n is asynchronous; reset homes the cursor and loads 80 x 25.
// ----------------------------------------------------------------------------
module text_console_cursor_controller
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] glyph, [14:7] cell_col,
                                        // [21:15] cell_row, [23:22] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] action
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    logic               q_valid;
    cmd_t               q_cmd;
    logic               q_pop;
    action_t            act;
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;

    assign cfg_ready = 1'b1;

    tcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser[0]),
        .in_code   (s_axis_tdata),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop)
    );

    tcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_sel    (cfg_index),
        .cfg_wdata  (cfg_data),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_action (act),
        .out_glyph  (glyph),
        .out_col    (cell_col),
        .out_row    (cell_row),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, cell_row, cell_col, glyph};
    assign m_axis_tuser = act;

endmodule

### tb/text_console_cursor_controller_test.sv
// ----------------------------------------------------------------------------
// text_console_cursor_controller_test
// Self-checking bench for the console cursor controller. Character and clear
// requests are streamed in from a queue, and a local cursor model predicts
// the draw, scroll and clear commands. Every command that comes out is
// checked field by field. Screen sizes are changed between phases. The
// phases cover the smallest screen, the largest screen, zero sizes and
// oversize values, and a cursor left off screen after a shrink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_controller_test;
    import tcc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 150000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic        op;
        logic [7:0]  code;
    } console_req_t;

    typedef struct {
        action_t              action;
        logic [GLYPH_W-1:0]   glyph;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } console_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_COLS;
    logic [8:0]  cfg_data = '0;

    console_req_t pending_reqs[$];
    console_cmd_t expected_cmds[$];

    // screen size mirror and cursor of the local model
    logic [COLS_W-1:0] model_cols = 9'd80;
    logic [ROWS_W-1:0] model_rows = 8'd25;
    int model_col = 0;
    int model_row = 0;

    int sender_gap_pct   = 16;
    int receiver_gap_pct = 16;
    int stall_req  = 0;
    int stall_ack  = 0;
    int stall_left = 0;

    int cycle_count    = 0;
    int reqs_accepted  = 0;
    int cmds_checked   = 0;
    int scrolls_seen   = 0;
    int clears_seen    = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;
    int unexpected     = 0;

    text_console_cursor_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // cursor model
    // ------------------------------------------------------------------------
    function automatic int screen_cols();
        int c;
        c = model_cols;
        if (c == 0) c = 1;
        if (c > MAX_COLUMNS) c = MAX_COLUMNS;
        return c;
    endfunction

    function automatic int screen_rows();
        int r;
        r = model_rows;
        if (r == 0) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    function automatic void push_cmd(action_t act, logic [GLYPH_W-1:0] g, int c, int r);
        console_cmd_t cmd;
        cmd.action = act;
        cmd.glyph  = g;
        cmd.col    = c[COL_W-1:0];
        cmd.row    = r[ROW_W-1:0];
        cmd.last   = 1'b0;
        expected_cmds.push_back(cmd);
    endfunction

    function automatic void settle_row();
        int rows;
        rows = screen_rows();
        if (model_row >= rows)
        begin
            push_cmd(ACT_SCROLL, '0, 0, 0);
            model_row = rows - 1;
        end
    endfunction

    function automatic void draw_cell(logic [CODE_W-1:0] code);
        logic [GLYPH_W-1:0] g;
        g = (code >= CHAR_HIGH) ? GLYPH_SUBST : code[GLYPH_W-1:0];
        push_cmd(ACT_DRAW, g, model_col, model_row);
        model_col++;
        if (model_col >= screen_cols())
        begin
            model_col = 0;
            model_row++;
        end
        settle_row();
    endfunction

    function automatic void predict_console(logic op, logic [CODE_W-1:0] code);
        int before_count;
        int spaces;
        console_cmd_t tail;
        before_count = expected_cmds.size();
        if (op == OP_CLEAR)
        begin
            push_cmd(ACT_CLEAR, '0, 0, 0);
            model_col = 0;
            model_row = 0;
        end
        else if (code == CHAR_NL)
        begin
            model_col = 0;
            model_row++;
            settle_row();
        end
        else if (code == CHAR_CR)
        begin
            model_col = 0;
            settle_row();
        end
        else if (code == CHAR_TAB)
        begin
            spaces = TAB_WIDTH - (model_col % TAB_WIDTH);
            repeat (spaces) draw_cell(CHAR_SPACE);
        end
        else if (code >= CHAR_PRINT_MIN)
            draw_cell(code);
        else
            settle_row();
        if (expected_cmds.size() > before_count)
        begin
            tail = expected_cmds.pop_back();
            tail.last = 1'b1;
            expected_cmds.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    console_req_t offer_req;

    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_console(s_axis_tuser[0], s_axis_tdata);
                reqs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_gap_pct)
                begin
                    offer_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offer_req.code;
                    s_axis_tuser  <= offer_req.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // command monitor
    // ------------------------------------------------------------------------
    task automatic check_cmd(logic [23:0] data, logic [1:0] user, logic tlast);
        console_cmd_t exp_cmd;
        if (expected_cmds.size() == 0)
        begin
            unexpected++;
            if (mismatches + unexpected <= MAX_REPORTS)
                $display("[%0t] unexpected command: action %0d data %h last %0b",
                         $realtime, user, data, tlast);
            return;
        end
        exp_cmd = expected_cmds.pop_front();
        cmds_checked++;
        if (user == ACT_SCROLL) scrolls_seen++;
        if (user == ACT_CLEAR)  clears_seen++;
        if (user !== exp_cmd.action || data[6:0] !== exp_cmd.glyph ||
            data[14:7] !== exp_cmd.col || data[21:15] !== exp_cmd.row ||
            data[23:22] !== 2'b00 || tlast !== exp_cmd.last)
        begin
            mismatches++;
            if (mismatches + unexpected <= MAX_REPORTS)
            begin
                $display("[%0t] expected action %0d glyph %h col %0d row %0d last %0b",
                         $realtime, exp_cmd.action, exp_cmd.glyph, exp_cmd.col,
                         exp_cmd.row, exp_cmd.last);
                $display("[%0t] got action %0d glyph %h col %0d row %0d last %0b pad %b",
                         $realtime, user, data[6:0], data[14:7], data[21:15],
                         tlast, data[23:22]);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_cmd(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (stall_req != stall_ack)
            begin
                stall_ack  = stall_req;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_gap_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, expected_cmds.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_req(logic op, logic [7:0] code);
        console_req_t r;
        r.op   = op;
        r.code = code;
        pending_reqs.push_back(r);
    endtask

    // mix of character classes; the weights are percentages
    task automatic queue_random(int count, int clear_pct, int tab_pct, int nl_pct);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < clear_pct)
                queue_req(OP_CLEAR, 8'($urandom_range(255)));
            else if (pick < clear_pct + tab_pct)
                queue_req(OP_PUT, CHAR_TAB);
            else if (pick < clear_pct + tab_pct + nl_pct)
                queue_req(OP_PUT, CHAR_NL);
            else if (pick < clear_pct + tab_pct + nl_pct + 5)
                queue_req(OP_PUT, CHAR_CR);
            else if (pick < clear_pct + tab_pct + nl_pct + 12)
                queue_req(OP_PUT, 8'($urandom_range(31)));
            else if (pick < clear_pct + tab_pct + nl_pct + 24)
                queue_req(OP_PUT, 8'($urandom_range(255, 128)));
            else
                queue_req(OP_PUT, 8'($urandom_range(127, 32)));
        end
    endtask

    // requests that produce nothing leave no trace, so allow the pipeline
    // to empty before touching the size registers
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_COLS)
            model_cols = value;
        else
            model_rows = value[ROWS_W-1:0];
        cfg_writes++;
    endtask

    task automatic set_screen(logic [8:0] cols, logic [8:0] rows);
        wait_drained();
        write_reg(REG_COLS, cols);
        write_reg(REG_ROWS, rows);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default 80 x 25 screen: every character class at least once
        queue_req(OP_PUT, 8'h41);
        queue_req(OP_PUT, CHAR_TAB);
        queue_req(OP_PUT, CHAR_TAB);
        queue_req(OP_PUT, 8'h00);
        queue_req(OP_PUT, 8'h1F);
        queue_req(OP_PUT, 8'h7F);
        queue_req(OP_PUT, 8'h80);
        queue_req(OP_PUT, 8'hFF);
        queue_req(OP_PUT, CHAR_SPACE);
        queue_req(OP_PUT, CHAR_CR);
        queue_req(OP_PUT, CHAR_NL);
        queue_req(OP_CLEAR, 8'hFF);
        queue_req(OP_PUT, CHAR_TAB);
        queue_req(OP_CLEAR, CHAR_NL);
        queue_req(OP_PUT, 8'h7E);

        // one-cell screen: every draw wraps and scrolls
        set_screen(9'd1, 9'd1);
        queue_req(OP_PUT, 8'h5A);
        queue_req(OP_PUT, CHAR_TAB);
        queue_req(OP_PUT, CHAR_NL);
        queue_req(OP_PUT, CHAR_CR);
        queue_req(OP_PUT, 8'h01);
        queue_req(OP_CLEAR, 8'h00);

        // zero sizes count as one
        set_screen(9'd0, 9'd0);
        queue_random(15, 5, 15, 15);

        // single column, tallest screen: walk the cursor down the screen
        set_screen(9'd1, 9'd128);
        queue_random(50, 0, 30, 30);

        // oversize values saturate; receiver stalls long enough to back up
        // the input side
        set_screen(9'h1FF, 9'h1FF);
        stall_req++;
        queue_random(30, 3, 10, 5);

        // shrink with the cursor far off screen
        set_screen(9'd7, 9'd3);
        queue_random(40, 5, 15, 10);

        // run with no idling on either side
        set_screen(9'($urandom_range(20, 2)), 9'($urandom_range(6, 2)));
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        queue_random(30, 5, 15, 10);

        wait_drained();

        $display("%0d requests, %0d commands checked (%0d scrolls, %0d clears)",
                 reqs_accepted, cmds_checked, scrolls_seen, clears_seen);
        $display("%0d size writes: one-cell, zero, 1x128, saturated, shrunk and random",
                 cfg_writes);
        if (mismatches == 0 && unexpected == 0 && expected_cmds.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            $display("%0d mismatches, %0d unexpected, %0d missing",
                     mismatches, unexpected, expected_cmds.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
